>>> src/fpsa_pkg.sv
// ----------------------------------------------------------------------------
// fpsa_pkg
// Shared constants, filter coefficients and the command and status types that
// join the servo axis controller to its datapath.
// ----------------------------------------------------------------------------
package fpsa_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 10;
  localparam int SERVO_LOW   = 900;
  localparam int SERVO_HIGH  = 2100;

  localparam logic signed [47:0] LO_Q     = 48'(SERVO_LOW << FRAC_BITS);
  localparam logic signed [47:0] HI_Q     = 48'(SERVO_HIGH << FRAC_BITS);
  localparam logic signed [47:0] CENTRE_Q = 48'((SERVO_LOW + SERVO_HIGH) << (FRAC_BITS - 1));
  localparam logic signed [47:0] ILIM_Q   = 48'(32768 << FRAC_BITS);
  localparam logic        [11:0] CENTRE_US = 12'((SERVO_LOW + SERVO_HIGH) / 2);
  localparam logic signed [16:0] SPAN_US  = 17'(SERVO_HIGH - SERVO_LOW);
  localparam logic signed [16:0] STEP_K   = 17'sd3277;

  // Register indexes.
  localparam logic [2:0] REG_PROP       = 3'd0;
  localparam logic [2:0] REG_INTEG      = 3'd1;
  localparam logic [2:0] REG_DERIV      = 3'd2;
  localparam logic [2:0] REG_FINE_PROP  = 3'd3;
  localparam logic [2:0] REG_FINE_DERIV = 3'd4;
  localparam logic [2:0] REG_FINE_BAND  = 3'd5;
  localparam logic [2:0] REG_POS_MIN    = 3'd6;
  localparam logic [2:0] REG_POS_MAX    = 3'd7;

  // Multiplier operand selects.
  localparam logic [2:0] MS_FILT = 3'd0;
  localparam logic [2:0] MS_MAP  = 3'd1;
  localparam logic [2:0] MS_KP   = 3'd2;
  localparam logic [2:0] MS_KD   = 3'd3;
  localparam logic [2:0] MS_STEP = 3'd4;
  localparam logic [2:0] MS_PRED = 3'd5;
  localparam logic [2:0] MS_OUT  = 3'd6;

  // Datapath operations.
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_ACC_CLR  = 4'd2;
  localparam logic [3:0] OP_ACC_ADD  = 4'd3;
  localparam logic [3:0] OP_FILT_OUT = 4'd4;
  localparam logic [3:0] OP_MAP_DIV  = 4'd5;
  localparam logic [3:0] OP_POS      = 4'd6;
  localparam logic [3:0] OP_ACC_LOAD = 4'd7;
  localparam logic [3:0] OP_STEP     = 4'd8;
  localparam logic [3:0] OP_PRED     = 4'd9;
  localparam logic [3:0] OP_DUTY     = 4'd10;
  localparam logic [3:0] OP_EMIT     = 4'd11;

  localparam logic [2:0] LAST_TAP = 3'd7;

  typedef struct packed {
    logic [2:0] mul_sel;
    logic [2:0] tap;
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic deg;
    logic div_done;
    logic out_free;
  } sts_t;

  // Filter taps: b0, b1, b2, b3 on inputs, then the negated a1, a2, a3 on outputs.
  function automatic logic signed [16:0] filt_coef(input logic [2:0] tap);
    logic signed [16:0] c;
    case (tap)
      3'd0:    c = 17'sd585;
      3'd1:    c = 17'sd1754;
      3'd2:    c = 17'sd1754;
      3'd3:    c = 17'sd585;
      3'd4:    c = 17'sd21622;
      3'd5:    c = -17'sd12787;
      3'd6:    c = 17'sd2544;
      default: c = 17'sd0;
    endcase
    return c;
  endfunction

endpackage

>>> src/filtered_pid_servo_axis.sv
// ----------------------------------------------------------------------------
// filtered_pid_servo_axis
// One servo axis: third-order low-pass filter, linear position mapping and a
// gain-scheduled PID with conditional anti-windup.
//
//   channel  direction  handshake            payload
//   input    in         in_valid/in_ready    sample
//   output   out        out_valid/out_ready  duty, filtered_pos, integ_held,
//                                            fine_regime
//   config   in         cfg_we               cfg_index, cfg_data
//
// The mapping divider dominates the time from acceptance until the result beat
// is offered; the filter taps run through one shared multiplier. With degenerate
// calibration the mapping and PID steps are skipped. One sample is in work at
// a time; a finished beat waits in the output register while the next sample
// is accepted, and a result that finds that register still full waits in the
// sequencer. Reset clears the sequencer, filter history and integrator.
// ----------------------------------------------------------------------------
module filtered_pid_servo_axis import fpsa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        duty,
  output logic signed [13:0] filtered_pos,
  output logic               integ_held,
  output logic               fine_regime,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cmd_t cmd;
  sts_t sts;

  fpsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpsa_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .duty         (duty),
    .filtered_pos (filtered_pos),
    .integ_held   (integ_held),
    .fine_regime  (fine_regime)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while another is in work");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty >= 12'd900 && duty <= 12'd2100)
    else $error("duty outside servo range");

  a_flags_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && duty == 12'd1500 && integ_held |-> !fine_regime || integ_held)
    else $error("inconsistent result flags");

endmodule

>>> src/fpsa_div.sv
// ----------------------------------------------------------------------------
// fpsa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpsa_div import fpsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [35:0] dividend,
  input  logic [11:0] divisor,
  output logic [35:0] quot,
  output logic        done
);

  logic        busy;
  logic [5:0]  cnt;
  logic [11:0] rem;
  logic [11:0] dsr;
  logic [12:0] shifted;
  logic [12:0] diff;
  logic        ge;

  assign shifted = {rem, quot[35]};
  assign diff    = shifted - {1'b0, dsr};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd35) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      rem  <= ge ? diff[11:0] : shifted[11:0];
      quot <= {quot[34:0], ge};
    end
  end

endmodule

>>> src/fpsa_datapath.sv
// ----------------------------------------------------------------------------
// fpsa_datapath
// Configuration registers, filter and PID state, shared multiplier, divider
// and the output register of the servo axis.
// ----------------------------------------------------------------------------
module fpsa_datapath import fpsa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [11:0]        sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        duty,
  output logic signed [13:0] filtered_pos,
  output logic               integ_held,
  output logic               fine_regime
);

  logic [15:0] prop_gain, integ_gain, deriv_gain, fine_prop_gain, fine_deriv_gain;
  logic [11:0] fine_band, pos_min, pos_max;

  logic signed [23:0] x0;
  logic signed [23:0] hx [3];
  logic signed [23:0] hy [3];
  logic signed [23:0] y0;
  logic signed [23:0] prev_duty;
  logic signed [31:0] integ;
  logic signed [47:0] acc;
  logic signed [47:0] pd;
  logic signed [24:0] err;
  logic signed [24:0] speed;
  logic signed [27:0] isum;
  logic               num_neg;
  logic               fine_r;
  logic               held_r;
  logic [11:0]        res_duty;
  logic signed [13:0] res_pos;

  logic signed [16:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [44:0] preg;
  logic signed [23:0] tap_val;
  logic signed [24:0] rel;

  logic signed [47:0] acc_rnd;
  logic signed [33:0] y_sh;
  logic signed [23:0] y_next;
  logic signed [24:0] y_wide;
  logic signed [24:0] y_mag;
  logic signed [14:0] ipart;
  logic signed [44:0] num_mag;
  logic [35:0]        quot;
  logic               div_done;
  logic signed [37:0] q_s;
  logic signed [37:0] q_lo;
  logic signed [23:0] pos;
  logic signed [24:0] err_c;
  logic [24:0]        err_mag;
  logic signed [47:0] step_c;
  logic signed [47:0] isum_c;
  logic signed [47:0] pterm;
  logic signed [47:0] pred;
  logic               held_c;
  logic signed [47:0] isum_w;
  logic signed [47:0] trial;
  logic signed [47:0] dq;
  logic signed [47:0] dq_cl;
  logic signed [47:0] dq_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= 16'd819;
      integ_gain      <= 16'd410;
      deriv_gain      <= 16'd9421;
      fine_prop_gain  <= 16'd164;
      fine_deriv_gain <= 16'd2867;
      fine_band       <= 12'd200;
      pos_min         <= 12'd410;
      pos_max         <= 12'd2540;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP:       prop_gain       <= cfg_data;
        REG_INTEG:      integ_gain      <= cfg_data;
        REG_DERIV:      deriv_gain      <= cfg_data;
        REG_FINE_PROP:  fine_prop_gain  <= cfg_data;
        REG_FINE_DERIV: fine_deriv_gain <= cfg_data;
        REG_FINE_BAND:  fine_band       <= cfg_data[11:0];
        REG_POS_MIN:    pos_min         <= cfg_data[11:0];
        REG_POS_MAX:    pos_max         <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.tap)
      3'd0:    tap_val = x0;
      3'd1:    tap_val = hx[0];
      3'd2:    tap_val = hx[1];
      3'd3:    tap_val = hx[2];
      3'd4:    tap_val = hy[0];
      3'd5:    tap_val = hy[1];
      3'd6:    tap_val = hy[2];
      default: tap_val = '0;
    endcase
  end

  assign rel = {y0[23], y0} - $signed({3'b000, pos_min, 10'b0});

  always_comb begin
    case (cmd.mul_sel)
      MS_FILT: begin
        mul_a = filt_coef(cmd.tap);
        mul_b = {{4{tap_val[23]}}, tap_val};
      end
      MS_MAP: begin
        mul_a = SPAN_US;
        mul_b = {{3{rel[24]}}, rel};
      end
      MS_KP: begin
        mul_a = fine_r ? {1'b0, fine_prop_gain} : {1'b0, prop_gain};
        mul_b = {{3{err[24]}}, err};
      end
      MS_KD: begin
        mul_a = fine_r ? {1'b0, fine_deriv_gain} : {1'b0, deriv_gain};
        mul_b = {{3{speed[24]}}, speed};
      end
      MS_STEP: begin
        mul_a = STEP_K;
        mul_b = {{3{err[24]}}, err};
      end
      MS_PRED: begin
        mul_a = {1'b0, integ_gain};
        mul_b = isum;
      end
      MS_OUT: begin
        mul_a = {1'b0, integ_gain};
        mul_b = integ[27:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    preg <= mul_a * mul_b;
  end

  // Filter output: round half up, shift by 14, saturate to 24 bits.
  assign acc_rnd = acc + 48'sd8192;
  assign y_sh    = acc_rnd[47:14];
  always_comb begin
    if (y_sh > 34'sd8388607) begin
      y_next = 24'sh7FFFFF;
    end else if (y_sh < -34'sd8388608) begin
      y_next = 24'sh800000;
    end else begin
      y_next = y_sh[23:0];
    end
  end
  assign y_wide = {y_next[23], y_next};
  assign y_mag  = y_next[23] ? -y_wide : y_wide;
  assign ipart  = y_next[23] ? -$signed({1'b0, y_mag[23:10]}) : $signed({1'b0, y_mag[23:10]});

  assign num_mag = preg[44] ? -preg : preg;

  fpsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_MAP_DIV),
    .dividend (num_mag[35:0]),
    .divisor  (pos_max - pos_min),
    .quot     (quot),
    .done     (div_done)
  );

  assign q_s  = num_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  assign q_lo = q_s + LO_Q[37:0];
  always_comb begin
    if (q_lo > 38'sd8388607) begin
      pos = 24'sh7FFFFF;
    end else if (q_lo < -38'sd8388608) begin
      pos = 24'sh800000;
    end else begin
      pos = q_lo[23:0];
    end
  end
  assign err_c   = {pos[23], pos} - CENTRE_Q[24:0];
  assign err_mag = err_c[24] ? 25'(-err_c) : 25'(err_c);

  assign step_c = (48'(preg) + 48'sd32768) >>> 16;
  assign isum_c = 48'(integ) + step_c;
  assign pterm  = (48'(preg) + 48'sd2048) >>> 12;
  assign pred   = pd - pterm;
  assign held_c = (pred > HI_Q && err < 0) || (pred < LO_Q && err > 0);
  assign isum_w = 48'(isum);
  always_comb begin
    if (isum_w > ILIM_Q) begin
      trial = ILIM_Q;
    end else if (isum_w < -ILIM_Q) begin
      trial = -ILIM_Q;
    end else begin
      trial = isum_w;
    end
  end

  assign dq = pd - pterm;
  always_comb begin
    dq_cl = dq;
    if (dq_cl < LO_Q) begin
      dq_cl = LO_Q;
    end
    if (dq_cl > HI_Q) begin
      dq_cl = HI_Q;
    end
  end
  assign dq_sh = dq_cl >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        hx[i] <= '0;
        hy[i] <= '0;
      end
      prev_duty <= '0;
      integ     <= '0;
    end else begin
      case (cmd.op)
        OP_FILT_OUT: begin
          hx[0] <= x0;
          hx[1] <= hx[0];
          hx[2] <= hx[1];
          hy[0] <= y_next;
          hy[1] <= hy[0];
          hy[2] <= hy[1];
          if (sts.deg) begin
            prev_duty <= CENTRE_Q[23:0];
          end
        end
        OP_POS: prev_duty <= pos;
        OP_PRED: begin
          if (!held_c) begin
            integ <= trial[31:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:     x0 <= $signed({2'b00, sample, 10'b0});
      OP_ACC_CLR:  acc <= '0;
      OP_ACC_ADD:  acc <= acc + 48'(preg);
      OP_ACC_LOAD: acc <= 48'(preg);
      OP_FILT_OUT: begin
        y0      <= y_next;
        res_pos <= ipart[13:0];
        if (sts.deg) begin
          res_duty <= CENTRE_US;
          held_r   <= 1'b0;
          fine_r   <= 1'b0;
        end
      end
      OP_MAP_DIV:  num_neg <= preg[44];
      OP_POS: begin
        err    <= err_c;
        speed  <= {pos[23], pos} - {prev_duty[23], prev_duty};
        fine_r <= err_mag < {3'b000, fine_band, 10'b0};
      end
      OP_STEP: begin
        pd   <= CENTRE_Q - ((acc + 48'sd2048) >>> 12);
        isum <= isum_c[27:0];
      end
      OP_PRED:     held_r   <= held_c;
      OP_DUTY:     res_duty <= dq_sh[11:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      duty         <= res_duty;
      filtered_pos <= res_pos;
      integ_held   <= held_r;
      fine_regime  <= fine_r;
    end
  end

  assign sts.deg      = pos_max <= pos_min;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || out_ready;

endmodule

>>> src/fpsa_ctrl.sv
// ----------------------------------------------------------------------------
// fpsa_ctrl
// Sequencer that steps the servo axis datapath through filter, mapping,
// division and PID phases for one sample at a time.
// ----------------------------------------------------------------------------
module fpsa_ctrl import fpsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILT  = 4'd1;
  localparam logic [3:0] S_FOUT  = 4'd2;
  localparam logic [3:0] S_MAPM  = 4'd3;
  localparam logic [3:0] S_MAPW  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_POS   = 4'd6;
  localparam logic [3:0] S_PD0   = 4'd7;
  localparam logic [3:0] S_PD1   = 4'd8;
  localparam logic [3:0] S_PD2   = 4'd9;
  localparam logic [3:0] S_STEP  = 4'd10;
  localparam logic [3:0] S_PRED0 = 4'd11;
  localparam logic [3:0] S_PRED1 = 4'd12;
  localparam logic [3:0] S_OUT0  = 4'd13;
  localparam logic [3:0] S_OUT1  = 4'd14;
  localparam logic [3:0] S_EMIT  = 4'd15;

  logic [3:0] state, state_next;
  logic [2:0] tap, tap_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next  = state;
    tap_next    = tap;
    cmd.mul_sel = MS_FILT;
    cmd.tap     = tap;
    cmd.op      = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          tap_next   = '0;
          state_next = S_FILT;
        end
      end
      S_FILT: begin
        cmd.op = (tap == 3'd0) ? OP_ACC_CLR : OP_ACC_ADD;
        if (tap == LAST_TAP) begin
          state_next = S_FOUT;
        end else begin
          tap_next = tap + 3'd1;
        end
      end
      S_FOUT: begin
        cmd.op     = OP_FILT_OUT;
        state_next = sts.deg ? S_EMIT : S_MAPM;
      end
      S_MAPM: begin
        cmd.mul_sel = MS_MAP;
        state_next  = S_MAPW;
      end
      S_MAPW: begin
        cmd.op     = OP_MAP_DIV;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_POS;
        end
      end
      S_POS: begin
        cmd.op     = OP_POS;
        state_next = S_PD0;
      end
      S_PD0: begin
        cmd.mul_sel = MS_KP;
        state_next  = S_PD1;
      end
      S_PD1: begin
        cmd.mul_sel = MS_KD;
        cmd.op      = OP_ACC_LOAD;
        state_next  = S_PD2;
      end
      S_PD2: begin
        cmd.mul_sel = MS_STEP;
        cmd.op      = OP_ACC_ADD;
        state_next  = S_STEP;
      end
      S_STEP: begin
        cmd.op     = OP_STEP;
        state_next = S_PRED0;
      end
      S_PRED0: begin
        cmd.mul_sel = MS_PRED;
        state_next  = S_PRED1;
      end
      S_PRED1: begin
        cmd.op     = OP_PRED;
        state_next = S_OUT0;
      end
      S_OUT0: begin
        cmd.mul_sel = MS_OUT;
        state_next  = S_OUT1;
      end
      S_OUT1: begin
        cmd.op     = OP_DUTY;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sim/tb_filtered_pid_servo_axis.sv
// ----------------------------------------------------------------------------
// tb_filtered_pid_servo_axis
// Self-checking bench for one servo axis. Samples are sent with random gaps
// and results are taken with random stalls. A behavioral model of the filter,
// the position mapping and the scheduled PID predicts each result beat, and
// the beats are compared field by field. The run steps through several gain
// and calibration settings, the degenerate calibration among them.
// ----------------------------------------------------------------------------
module tb_filtered_pid_servo_axis import fpsa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0]        duty;
    logic signed [13:0] pos;
    logic               held;
    logic               fine;
  } servo_beat_t;

  typedef struct {
    logic [11:0] smp;
    logic        known;
    servo_beat_t res;
  } vec_row_t;

  localparam longint S24_MAX = 64'sd8388607;
  localparam longint S24_MIN = -64'sd8388608;
  localparam longint LIMIT_CYCLES = 64'd2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [11:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [11:0] duty;
  logic signed [13:0] filtered_pos;
  logic integ_held;
  logic fine_regime;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  filtered_pid_servo_axis u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Model state and registers.
  longint gain_r[8];
  longint x_hist[3];
  longint y_hist[3];
  longint last_pos;
  longint integ;

  servo_beat_t expected_beats[$];
  int errors = 0;
  longint cycles = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint rnd_shr(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic servo_beat_t servo_predict(logic [11:0] smp);
    servo_beat_t r;
    longint x0, acc, y0, ip, dq, span, p, err, spd, mag, kp, kd, pd, stp, lim, trial, pred;
    x0 = longint'(smp) << FRAC_BITS;
    acc = 585 * x0 + 1754 * x_hist[0] + 1754 * x_hist[1] + 585 * x_hist[2]
        + 21622 * y_hist[0] - 12787 * y_hist[1] + 2544 * y_hist[2];
    y0 = clip(rnd_shr(acc, 14), S24_MIN, S24_MAX);
    x_hist[2] = x_hist[1]; x_hist[1] = x_hist[0]; x_hist[0] = x0;
    y_hist[2] = y_hist[1]; y_hist[1] = y_hist[0]; y_hist[0] = y0;
    ip = y0 >= 0 ? (y0 >>> FRAC_BITS) : -((-y0) >>> FRAC_BITS);
    ip = clip(ip, -8192, 8191);
    r.held = 1'b0;
    r.fine = 1'b0;
    if (gain_r[REG_POS_MAX] <= gain_r[REG_POS_MIN]) begin
      last_pos = CENTRE_Q;
      dq = CENTRE_Q;
    end else begin
      span = gain_r[REG_POS_MAX] - gain_r[REG_POS_MIN];
      p = (y0 - (gain_r[REG_POS_MIN] << FRAC_BITS)) * (SERVO_HIGH - SERVO_LOW);
      p = clip(p / span + LO_Q, S24_MIN, S24_MAX);
      err = p - CENTRE_Q;
      spd = p - last_pos;
      last_pos = p;
      mag = err < 0 ? -err : err;
      if (mag < (gain_r[REG_FINE_BAND] << FRAC_BITS)) begin
        r.fine = 1'b1;
        kp = gain_r[REG_FINE_PROP];
        kd = gain_r[REG_FINE_DERIV];
      end else begin
        kp = gain_r[REG_PROP];
        kd = gain_r[REG_DERIV];
      end
      pd = CENTRE_Q - rnd_shr(kp * err + kd * spd, 12);
      stp = rnd_shr(err * 3277, 16);
      lim = ILIM_Q;
      trial = clip(integ + stp, -lim, lim);
      pred = pd - rnd_shr(gain_r[REG_INTEG] * (integ + stp), 12);
      if ((pred > HI_Q && err < 0) || (pred < LO_Q && err > 0)) r.held = 1'b1;
      else integ = trial;
      dq = pd - rnd_shr(gain_r[REG_INTEG] * integ, 12);
    end
    dq = clip(dq, LO_Q, HI_Q);
    r.duty = 12'(dq >>> FRAC_BITS);
    r.pos = 14'(ip);
    return r;
  endfunction

  // In the degenerate row only duty is read off directly; the filter output
  // still comes from the running history, so it is taken from the prediction.
  function automatic logic signed [13:0] filtered_pos_skip();
    longint x0, acc, y0;
    x0 = longint'(12'd4095) << FRAC_BITS;
    acc = 585 * x0 + 1754 * x_hist[0] + 1754 * x_hist[1] + 585 * x_hist[2]
        + 21622 * y_hist[0] - 12787 * y_hist[1] + 2544 * y_hist[2];
    y0 = clip(rnd_shr(acc, 14), S24_MIN, S24_MAX);
    return 14'(clip(y0 >= 0 ? (y0 >>> FRAC_BITS) : -((-y0) >>> FRAC_BITS), -8192, 8191));
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_r[idx] = (idx >= REG_FINE_BAND) ? longint'(val[11:0]) : longint'(val);
    @(posedge clk);
  endtask

  task automatic send_sample(logic [11:0] smp, logic known, servo_beat_t res);
    servo_beat_t p;
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p = servo_predict(smp);
    if (known) begin
      if (p.duty !== res.duty) begin
        $error("duty expected %0d actual %0d", res.duty, p.duty); errors++;
      end
      if (p.pos !== res.pos) begin
        $error("filtered_pos expected %0d actual %0d", res.pos, p.pos); errors++;
      end
      if (p.held !== res.held) begin
        $error("integ_held expected %0d actual %0d", res.held, p.held); errors++;
      end
      if (p.fine !== res.fine) begin
        $error("fine_regime expected %0d actual %0d", res.fine, p.fine); errors++;
      end
    end
    expected_beats.push_back(p);
    in_valid <= 1'b1;
    sample <= smp;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("filtered_pid_servo_axis test failed");
      $finish;
    end
  end

  // Result side: random stalls and comparison against the oldest prediction.
  initial begin
    int stall;
    servo_beat_t e;
    @(negedge rst);
    stall = $urandom_range(0, 4);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          e = expected_beats.pop_front();
          if (duty !== e.duty) begin
            $error("duty expected %0d actual %0d", e.duty, duty); errors++;
          end
          if (filtered_pos !== e.pos) begin
            $error("filtered_pos expected %0d actual %0d", e.pos, filtered_pos); errors++;
          end
          if (integ_held !== e.held) begin
            $error("integ_held expected %0d actual %0d", e.held, integ_held); errors++;
          end
          if (fine_regime !== e.fine) begin
            $error("fine_regime expected %0d actual %0d", e.fine, fine_regime); errors++;
          end
        end
        stall = $urandom_range(0, 4);
      end
      if (stall > 0 && (cycles % 512) < 400) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  vec_row_t vecs[$];

  initial begin
    servo_beat_t z;
    int n, mode;
    logic [11:0] s;
    gain_r = '{819, 410, 9421, 164, 2867, 200, 410, 2540};
    x_hist = '{0, 0, 0};
    y_hist = '{0, 0, 0};
    last_pos = 0;
    integ = 0;
    z = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: the first beat from reset is readable directly.
    vecs.push_back('{12'd0, 1'b1, '{12'd900, 14'sd0, 1'b0, 1'b0}});
    vecs.push_back('{12'd4095, 1'b0, z});
    vecs.push_back('{12'd4095, 1'b0, z});
    vecs.push_back('{12'd4095, 1'b0, z});
    vecs.push_back('{12'd0, 1'b0, z});
    vecs.push_back('{12'd1475, 1'b0, z});
    vecs.push_back('{12'd1475, 1'b0, z});
    vecs.push_back('{12'd1475, 1'b0, z});
    vecs.push_back('{12'd2730, 1'b0, z});
    vecs.push_back('{12'd1365, 1'b0, z});
    vecs.push_back('{12'd410, 1'b0, z});
    vecs.push_back('{12'd2540, 1'b0, z});
    foreach (vecs[i]) send_sample(vecs[i].smp, vecs[i].known, vecs[i].res);
    drain();

    // Degenerate calibration: centre duty.
    write_reg(REG_POS_MIN, 16'd4095);
    write_reg(REG_POS_MAX, 16'd0);
    send_sample(12'd4095, 1'b1, '{12'd1500, filtered_pos_skip(), 1'b0, 1'b0});
    for (int i = 0; i < 5; i++) send_sample(12'(i * 1000), 1'b0, z);
    drain();
    write_reg(REG_POS_MAX, 16'd4095);
    for (int i = 0; i < 4; i++) send_sample(12'd4095, 1'b0, z);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      mode = phase % 4;
      for (int r = 0; r < 8; r++) begin
        if (mode == 0) write_reg(3'(r), 16'hFFFF);
        else if (mode == 1) write_reg(3'(r), 16'h0000);
        else write_reg(3'(r), 16'($urandom));
      end
      if (mode != 1) begin
        write_reg(REG_POS_MIN, 16'($urandom_range(0, 1500)));
        write_reg(REG_POS_MAX, 16'($urandom_range(1600, 4095)));
        if (mode == 3) write_reg(REG_FINE_BAND, 16'($urandom_range(0, 800)));
      end
      if (phase == 7) begin
        write_reg(REG_PROP, 16'd819); write_reg(REG_INTEG, 16'd410);
        write_reg(REG_DERIV, 16'd9421); write_reg(REG_FINE_PROP, 16'd164);
        write_reg(REG_FINE_DERIV, 16'd2867); write_reg(REG_FINE_BAND, 16'd200);
        write_reg(REG_POS_MIN, 16'd410); write_reg(REG_POS_MAX, 16'd2540);
      end
      s = 12'($urandom);
      n = 190;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: s = 12'($urandom);
          1: s = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
          default: s = 12'(clip(longint'(s) + $urandom_range(0, 200) - 100, 0, 4095));
        endcase
        send_sample(s, 1'b0, z);
      end
      drain();
    end
    if (errors == 0) begin
      $display("filtered_pid_servo_axis test passed");
    end else begin
      $display("filtered_pid_servo_axis test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/fpsa_pkg.sv
src/fpsa_div.sv
src/fpsa_datapath.sv
src/fpsa_ctrl.sv
src/filtered_pid_servo_axis.sv
sim/tb_filtered_pid_servo_axis.sv
